// ----- sv/rvn_pkg.sv -----
// shared types and constants for the random unit vector normalizer
package rvn_pkg;

  localparam int NumAxes = 3;
  localparam int RootBits = 16;

  // accepted squared norm range, Q2.32
  localparam logic [34:0] NormMax = 35'h1_0000_0000;
  localparam logic [34:0] NormMin = 35'd429497;

  typedef struct packed {
    logic [17:0] sample_x;
    logic [17:0] sample_y;
    logic [17:0] sample_z;
  } rvn_in_t;

  typedef struct packed {
    logic               accepted;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
  } rvn_out_t;

  // one step of the bit-per-stage root recurrence, all three axes
  typedef struct packed {
    logic                              ok;
    logic [NumAxes-1:0]                neg;
    logic [32:0]                       n;
    logic [NumAxes-1:0][64:0]          r;
    logic [NumAxes-1:0][48:0]          tn;
    logic [NumAxes-1:0][RootBits-1:0]  t;
  } rvn_root_t;

endpackage

// ----- sv/rvn_root_stage.sv -----
// one pipeline stage of the scaled square root: decides result bit K for each axis
module rvn_root_stage #(
  parameter int K = 15
) (
  input  logic              clk,
  input  logic              load,
  input  rvn_pkg::rvn_root_t d,
  output rvn_pkg::rvn_root_t q
);
  import rvn_pkg::*;

  logic [65:0] delta [NumAxes];
  logic [65:0] rext  [NumAxes];
  rvn_root_t   nxt;

  // trying bit k: (t + 2^k)^2 n - t^2 n = (t n) 2^(k+1) + n 2^(2k)
  always_comb begin
    nxt = d;
    for (int i = 0; i < NumAxes; i++) begin
      rext[i]  = {1'b0, d.r[i]};
      delta[i] = ({17'b0, d.tn[i]} << (K + 1)) + ({33'b0, d.n} << (2 * K));
      if (delta[i] <= rext[i]) begin
        nxt.r[i]  = 65'(rext[i] - delta[i]);
        nxt.tn[i] = d.tn[i] + ({16'b0, d.n} << K);
        nxt.t[i]  = d.t[i] | (RootBits'(1) << K);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q <= nxt;
    end
  end

endmodule

// ----- sv/random_unit_vector_normalizer_core.sv -----
// Random unit vector normalizer: maps three Q2.16 samples to 2s-1, clamps to [-1,1],
// rejects the triple when the squared norm is above 1.0 or below 0.0001, and
// otherwise returns the vector over its norm as Q1.15 components rounded to
// nearest. One request is taken every cycle while the pipeline is not stalled; the
// pipeline has three front stages (map, square, sum and range check), sixteen stages
// of the square root recurrence that settle one result bit each, and the output
// register. Each stage holds while the stage after it is full and stalled, so
// bubbles close up and new requests are still taken until the stall reaches the input.
module random_unit_vector_normalizer_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  rvn_pkg::rvn_in_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output rvn_pkg::rvn_out_t out_data
);
  import rvn_pkg::*;

  localparam int NumStages = RootBits + 4;
  localparam int OutStage  = NumStages - 1;

  logic [NumStages-1:0] valid;
  logic [NumStages:0]   rdy;
  logic [NumStages-1:0] adv;

  // handshake chain: a stage loads when it is empty or its contents move on
  assign rdy[NumStages] = out_ready;
  for (genvar s = 0; s < NumStages; s++) begin : g_ctl
    assign rdy[s] = !valid[s] || rdy[s+1];
    if (s == 0) begin : g_first
      assign adv[s] = in_valid && rdy[s];
    end else begin : g_rest
      assign adv[s] = valid[s-1] && rdy[s];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        valid[s] <= 1'b0;
      end else if (rdy[s]) begin
        valid[s] <= (s == 0) ? in_valid : valid[s-1];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = valid[OutStage];

  // stage a: map 2s-1 and clamp
  logic [17:0]        raw    [NumAxes];
  logic signed [19:0] wide   [NumAxes];
  logic signed [17:0] v_next [NumAxes];
  logic signed [17:0] v      [NumAxes];

  assign raw[0] = in_data.sample_x;
  assign raw[1] = in_data.sample_y;
  assign raw[2] = in_data.sample_z;

  always_comb begin
    for (int i = 0; i < NumAxes; i++) begin
      wide[i] = signed'({1'b0, raw[i], 1'b0}) - 20'sd65536;
      if (wide[i] > 20'sd65536) begin
        v_next[i] = 18'sd65536;
      end else if (wide[i] < -20'sd65536) begin
        v_next[i] = -18'sd65536;
      end else begin
        v_next[i] = 18'(wide[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      v <= v_next;
    end
  end

  // stage b: squares
  logic [16:0] mag     [NumAxes];
  logic [33:0] prod    [NumAxes];
  logic [32:0] sq      [NumAxes];
  logic [NumAxes-1:0] neg_b;

  always_comb begin
    for (int i = 0; i < NumAxes; i++) begin
      mag[i]  = v[i][17] ? 17'(-v[i]) : 17'(v[i]);
      prod[i] = mag[i] * mag[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int i = 0; i < NumAxes; i++) begin
        sq[i]    <= prod[i][32:0];
        neg_b[i] <= v[i][17];
      end
    end
  end

  // stage c: norm, range check and recurrence start
  logic [34:0] norm;
  rvn_root_t   root_init;
  rvn_root_t   root [RootBits+1];

  always_comb begin
    norm = {2'b0, sq[0]} + {2'b0, sq[1]} + {2'b0, sq[2]};
    root_init.ok  = !(norm > NormMax || norm < NormMin);
    root_init.neg = neg_b;
    root_init.n   = norm[32:0];
    for (int i = 0; i < NumAxes; i++) begin
      root_init.r[i]  = {sq[i], 32'b0};
      root_init.tn[i] = '0;
      root_init.t[i]  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      root[0] <= root_init;
    end
  end

  // sixteen root stages, most significant bit first
  for (genvar j = 0; j < RootBits; j++) begin : g_root
    rvn_root_stage #(
      .K(RootBits - 1 - j)
    ) u_stage (
      .clk  (clk),
      .load (adv[3+j]),
      .d    (root[j]),
      .q    (root[j+1])
    );
  end

  // output stage: round half up on the doubled root, sign and saturate
  logic [16:0] rnd  [NumAxes];
  logic [15:0] mg   [NumAxes];
  logic [15:0] dirv [NumAxes];
  rvn_out_t    out_next;

  always_comb begin
    for (int i = 0; i < NumAxes; i++) begin
      rnd[i] = {1'b0, root[RootBits].t[i]} + 17'd1;
      mg[i]  = rnd[i][16:1];
      if (!root[RootBits].ok) begin
        dirv[i] = '0;
      end else if (root[RootBits].neg[i]) begin
        dirv[i] = 16'(-mg[i]);
      end else if (mg[i][15]) begin
        dirv[i] = 16'h7fff;
      end else begin
        dirv[i] = mg[i];
      end
    end
    out_next.accepted = root[RootBits].ok;
    out_next.dir_x    = signed'(dirv[0]);
    out_next.dir_y    = signed'(dirv[1]);
    out_next.dir_z    = signed'(dirv[2]);
  end

  always_ff @(posedge clk) begin
    if (adv[OutStage]) begin
      out_data <= out_next;
    end
  end

endmodule

// ----- sv/rvn_checker.sv -----
// port-level checks for the random unit vector normalizer, bound to the top level
module rvn_port_checks (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input rvn_pkg::rvn_in_t  in_data,
  input logic             out_valid,
  input logic             out_ready,
  input rvn_pkg::rvn_out_t out_data
);
  import rvn_pkg::*;

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  // rejected triples carry zero components
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.accepted |->
      out_data.dir_x == 16'sd0 && out_data.dir_y == 16'sd0 && out_data.dir_z == 16'sd0)
    else $error("rejected result with nonzero direction");

  // an accepted vector has at least one nonzero component
  a_accept_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.accepted |->
      out_data.dir_x != 16'sd0 || out_data.dir_y != 16'sd0 || out_data.dir_z != 16'sd0)
    else $error("accepted result with zero direction");

  // an empty output means the pipeline can take a request
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("request refused with empty output");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) && !rst |-> !out_valid)
    else $error("result present after reset");

endmodule

bind random_unit_vector_normalizer_core rvn_port_checks u_rvn_checker (.*);

// ----- verif/rvn_checker.sv -----
// predicts and compares unit vector results seen on the normalizer's two channels
module rvn_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  rvn_pkg::rvn_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  rvn_pkg::rvn_out_t out_data,
  output int                fail_count,
  output int                pending,
  output int                checked,
  output int                accepted_count
);
  import rvn_pkg::*;

  localparam int ReportLimit = 10;

  rvn_out_t vectors_due[$];
  int errors = 0;
  int seen = 0;
  int hits = 0;

  // 2s-1 in Q1.16, clamped to [-1,1]
  function automatic logic signed [17:0] axis_value(logic [17:0] raw);
    logic signed [19:0] v;
    v = $signed({1'b0, raw, 1'b0}) - 20'sd65536;
    if (v > 20'sd65536) v = 20'sd65536;
    return 18'(v);
  endfunction

  // round(32768 * v / sqrt(n)), nearest with ties away from zero
  function automatic logic [15:0] unit_component(logic signed [17:0] v, logic [34:0] n);
    logic [16:0] mag;
    logic [33:0] sq;
    logic [95:0] rhs;
    logic [95:0] lhs;
    logic [15:0] t;
    logic [15:0] trial;
    logic [16:0] d;
    mag = v[17] ? 17'(-v) : 17'(v);
    sq = mag * mag;
    if ({1'b0, sq} == n) begin
      d = 17'd32768;
    end else begin
      // t carries one guard bit: largest t with t*t*n <= sq * 2^32
      rhs = {sq, 32'b0};
      t = '0;
      for (int b = 15; b >= 0; b--) begin
        trial = t | (16'd1 << b);
        lhs = 96'(trial) * 96'(trial) * 96'(n);
        if (lhs <= rhs) t = trial;
      end
      d = (17'(t) + 17'd1) >> 1;
    end
    if (v[17]) return 16'(17'd0 - d);
    if (d > 17'd32767) return 16'd32767;
    return d[15:0];
  endfunction

  function automatic rvn_out_t unit_vector(rvn_in_t req);
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic signed [17:0] z;
    logic [34:0] n;
    rvn_out_t r;
    x = axis_value(req.sample_x);
    y = axis_value(req.sample_y);
    z = axis_value(req.sample_z);
    n = 35'(34'(x) * 34'(x)) + 35'(34'(y) * 34'(y)) + 35'(34'(z) * 34'(z));
    r = '0;
    if (n <= NormMax && n >= NormMin) begin
      r.accepted = 1'b1;
      r.dir_x = unit_component(x, n);
      r.dir_y = unit_component(y, n);
      r.dir_z = unit_component(z, n);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    rvn_out_t want;
    if (rst) begin
      vectors_due.delete();
    end else begin
      if (in_valid && in_ready) vectors_due.push_back(unit_vector(in_data));
      if (out_valid && out_ready) begin
        seen++;
        if (vectors_due.size() == 0) begin
          errors++;
          if (errors <= ReportLimit)
            $display("unexpected result acc=%0d x=%0d y=%0d z=%0d", out_data.accepted,
                     out_data.dir_x, out_data.dir_y, out_data.dir_z);
        end else begin
          want = vectors_due.pop_front();
          if (want.accepted) hits++;
          if (want.accepted !== out_data.accepted || want.dir_x !== out_data.dir_x ||
              want.dir_y !== out_data.dir_y || want.dir_z !== out_data.dir_z) begin
            errors++;
            if (errors <= ReportLimit)
              $display({"mismatch on result %0d: expected acc=%0d x=%0d y=%0d z=%0d,",
                        " got acc=%0d x=%0d y=%0d z=%0d"},
                       seen, want.accepted, want.dir_x, want.dir_y, want.dir_z,
                       out_data.accepted, out_data.dir_x, out_data.dir_y, out_data.dir_z);
          end
        end
      end
    end
    fail_count <= errors;
    pending <= vectors_due.size();
    checked <= seen;
    accepted_count <= hits;
  end

endmodule

// ----- verif/tb_top.sv -----
// drives triples into the unit vector normalizer and reports the verdict
module tb_top;
  import rvn_pkg::*;

  localparam int NumRandom = 1150;
  localparam int CycleLimit = 200000;
  localparam int DrainCycles = 40;
  localparam int IdlePercent = 11;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_ready;
  rvn_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  rvn_out_t out_data;
  logic     calm = 1'b0;
  int       cycles = 0;
  int       fail_count;
  int       pending;
  int       checked;
  int       accepted_count;

  always #4 clk = ~clk;

  random_unit_vector_normalizer_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  rvn_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .fail_count     (fail_count),
    .pending        (pending),
    .checked        (checked),
    .accepted_count (accepted_count)
  );

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= IdlePercent);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // raw sample for an even Q1.16 value in [-1,1]
  function automatic logic [17:0] raw_of(int v);
    return 18'((v + 65536) / 2);
  endfunction

  function automatic rvn_in_t random_request();
    int v[3];
    int kind;
    int rot;
    int z;
    longint rem;
    rvn_in_t req;
    kind = $urandom_range(0, 99);
    for (int a = 0; a < 3; a++) v[a] = 2 * $urandom_range(0, 65536) - 65536;
    if (kind < 85 && kind >= 70) begin
      // land close to the unit sphere so the upper bound gets exercised
      v[0] = 2 * $urandom_range(0, 46000) - 46000;
      v[1] = 2 * $urandom_range(0, 46000) - 46000;
      rem = 64'd4294967296 - longint'(v[0]) * v[0] - longint'(v[1]) * v[1];
      z = (rem > 0) ? $rtoi($sqrt(real'(rem))) : 0;
      z = (z & ~1) + 2 * ($urandom_range(0, 6) - 3);
      if (z < 0) z = 0;
      if (z > 65536) z = 65536;
      v[2] = $urandom_range(0, 1) ? -z : z;
    end else if (kind < 95 && kind >= 85) begin
      // tiny vectors around the lower bound
      for (int a = 0; a < 3; a++) v[a] = 2 * $urandom_range(0, 700) - 700;
    end else if (kind >= 95) begin
      v[0] = $urandom_range(0, 1) ? 65536 : -65536;
      v[1] = 2 * $urandom_range(0, 200) - 200;
      v[2] = 2 * $urandom_range(0, 200) - 200;
    end
    rot = $urandom_range(0, 2);
    req.sample_x = raw_of(v[rot]);
    req.sample_y = raw_of(v[(rot + 1) % 3]);
    req.sample_z = raw_of(v[(rot + 2) % 3]);
    if (kind >= 55 && kind < 70) begin
      req.sample_x = 18'($urandom_range(0, 262143));
      req.sample_y = 18'($urandom_range(0, 262143));
      req.sample_z = 18'($urandom_range(0, 262143));
    end
    return req;
  endfunction

  task automatic send_request(input rvn_in_t req);
    while (!calm && $urandom_range(0, 99) < IdlePercent) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_raw(input logic [17:0] sx, input logic [17:0] sy,
                          input logic [17:0] sz);
    rvn_in_t req;
    req.sample_x = sx;
    req.sample_y = sy;
    req.sample_z = sz;
    send_request(req);
  endtask

  task automatic send_vec(input int x, input int y, input int z);
    send_raw(raw_of(x), raw_of(y), raw_of(z));
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_vec(0, 0, 0);                      // zero norm
    send_raw(18'd0, 18'd0, 18'd0);          // all at -1, far outside
    send_raw(18'h3FFFF, 18'h3FFFF, 18'h3FFFF);
    send_vec(65536, 0, 0);                  // full scale saturates
    send_vec(-65536, 0, 0);
    send_vec(0, 65536, 0);
    send_vec(0, 0, -65536);
    send_raw(18'd98305, raw_of(0), raw_of(0));   // above 1.0 clamps
    send_raw(raw_of(0), 18'd200000, raw_of(0));
    send_vec(654, 0, 0);                    // just under the lower bound
    send_vec(656, 0, 0);
    send_vec(0, -656, 0);
    send_vec(462, 462, 0);
    send_vec(464, 0, -464);
    send_vec(65536, 2, 0);                  // just over the unit norm
    send_vec(65534, 0, 2);
    send_vec(37838, 37838, 37838);
    send_vec(37836, -37836, 37836);
    send_vec(-30000, 20000, -40000);
    send_vec(40000, -40000, 2);
    send_vec(2, 0, 0);
    send_vec(-46340, -46340, 0);

    for (int i = 0; i < NumRandom; i++) begin
      calm <= (i >= 450 && i < 750);
      send_request(random_request());
    end
    in_valid <= 1'b0;
    calm <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (DrainCycles) @(posedge clk);

    $display("run covered %0d triples: %0d normalized, %0d rejected", checked,
             accepted_count, checked - accepted_count);
    $display("stimulus mixed in-range, clamped, near-unit and near-zero norms with stalls");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- random_unit_vector_normalizer_core.f -----
sv/rvn_pkg.sv
sv/rvn_root_stage.sv
sv/random_unit_vector_normalizer_core.sv
sv/rvn_checker.sv
verif/rvn_checker.sv
verif/tb_top.sv
